### rtl/dive_log_sample_decoder_macros.svh
// Assertion shorthands for the checker of this block.
`ifndef DIVE_LOG_SAMPLE_DECODER_MACROS_SVH
`define DIVE_LOG_SAMPLE_DECODER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define DLSD_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dlsd same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define DLSD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dlsd next-cycle check failed");

`endif

### rtl/dlsd_pkg.sv
package dlsd_pkg;

    // Width of the running totals; outputs are sign-extended or cut to 32 bits.
    localparam int TOTAL_WIDTH = 32;
    typedef logic [TOTAL_WIDTH-1:0] total_t;

    localparam int HDR_W = 10;
    localparam logic [HDR_W-1:0] HEADER_LENGTH_RESET = 10'd152;

    // Queue depths, powers of two.
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int RESQ_DEPTH = 4;
    localparam int RESQ_PTR_W = $clog2(RESQ_DEPTH);

    typedef enum logic [3:0] {
        KIND_TIME        = 4'd0,
        KIND_DEPTH       = 4'd1,
        KIND_PRESSURE    = 4'd2,
        KIND_TEMPERATURE = 4'd3,
        KIND_RBT         = 4'd4,
        KIND_HEARTRATE   = 4'd5,
        KIND_BEARING     = 4'd6,
        KIND_ALARMS      = 4'd7,
        KIND_ERROR       = 4'd8
    } kind_e;

    typedef enum logic [1:0] {
        OP_CLEAR_ONLY = 2'd0,
        OP_DECODE     = 2'd1,
        OP_ERROR      = 2'd2
    } op_e;

    // Record ids: single-byte classes, then 16 + low nibble of an Fx code.
    localparam logic [4:0] ID_DDEPTH   = 5'd0;
    localparam logic [4:0] ID_DRBT     = 5'd1;
    localparam logic [4:0] ID_DPRESS   = 5'd2;
    localparam logic [4:0] ID_DTEMP    = 5'd3;
    localparam logic [4:0] ID_TIME     = 5'd4;
    localparam logic [4:0] ID_DHR      = 5'd5;
    localparam logic [4:0] ID_ALARM_S  = 5'd6;
    localparam logic [4:0] ID_ALARM_F0 = 5'd16;
    localparam logic [4:0] ID_ADEPTH   = 5'd17;
    localparam logic [4:0] ID_ARBT     = 5'd18;
    localparam logic [4:0] ID_ATEMP    = 5'd19;
    localparam logic [4:0] ID_APRESS0  = 5'd20;
    localparam logic [4:0] ID_APRESS1  = 5'd21;
    localparam logic [4:0] ID_APRESS2  = 5'd22;
    localparam logic [4:0] ID_AHR      = 5'd23;
    localparam logic [4:0] ID_BEARING  = 5'd24;
    localparam logic [4:0] ID_ALARM_F9 = 5'd25;

    localparam logic [7:0] MASK_TOP3 = 8'hE0;
    localparam logic [7:0] PFX_DRBT  = 8'h80;
    localparam logic [7:0] MASK_TOP4 = 8'hF0;
    localparam logic [7:0] PFX_EXT   = 8'hF0;
    localparam logic [3:0] EXT_LAST  = 4'd9;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        kind_e              sample_kind;
        logic signed [31:0] sample_value;
        logic [1:0]         tank_index;
        logic               last_of_run;
    } sample_t;

    typedef struct packed {
        logic        clear;
        op_e         op;
        logic [4:0]  id;
        logic [15:0] value;
    } cmd_t;

    // Payload bytes that follow an Fx code.
    function automatic logic [1:0] ext_extra_bytes(input logic [3:0] lo);
        logic [1:0] n;
        unique case (lo)
            4'h0, 4'h2, 4'h7, 4'h9: n = 2'd1;
            default:                n = 2'd2;
        endcase
        return n;
    endfunction

    function automatic logic signed [31:0] to_out(input total_t v);
        return 32'($signed(v));
    endfunction

endpackage

### rtl/dlsd_front.sv
module dlsd_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [dlsd_pkg::HDR_W-1:0]  cfg_data,
    input  logic                        push,
    input  dlsd_pkg::item_t             item,
    output logic                        full,
    input  logic                        cmdq_full,
    output logic                        cmd_push,
    output dlsd_pkg::cmd_t              cmd
);

    logic [dlsd_pkg::HDR_W-1:0] header_length_reg;
    logic [dlsd_pkg::HDR_W-1:0] header_left_reg, header_left_next;
    logic [1:0]                 pending_reg, pending_next;
    logic [4:0]                 rtype_reg, rtype_next;
    logic [15:0]                asm_reg, asm_next;

    logic                       accept;
    logic                       emit;
    logic [dlsd_pkg::HDR_W-1:0] hl_eff;
    logic [1:0]                 pend_eff;
    logic [4:0]                 rtype_eff;
    logic [15:0]                asm_eff;
    logic [7:0]                 b;
    logic [3:0]                 lo;

    assign cfg_ready = 1'b1;
    assign full      = cmdq_full;
    assign accept    = push && !cmdq_full;
    assign cmd_push  = accept && emit;
    assign b         = item.data_byte;
    assign lo        = item.data_byte[3:0];

    always_comb
    begin
        // first_byte restarts the dive before this byte is looked at
        hl_eff    = item.first_byte ? header_length_reg : header_left_reg;
        pend_eff  = item.first_byte ? 2'd0 : pending_reg;
        rtype_eff = item.first_byte ? 5'd0 : rtype_reg;
        asm_eff   = item.first_byte ? 16'd0 : asm_reg;

        header_left_next = hl_eff;
        pending_next     = pend_eff;
        rtype_next       = rtype_eff;
        asm_next         = asm_eff;

        emit      = item.first_byte;
        cmd.clear = item.first_byte;
        cmd.op    = dlsd_pkg::OP_CLEAR_ONLY;
        cmd.id    = dlsd_pkg::ID_DDEPTH;
        cmd.value = 16'd0;

        priority if (hl_eff != '0)
        begin
            header_left_next = hl_eff - 1'b1;
        end
        else if (pend_eff != 2'd0)
        begin
            asm_next     = {asm_eff[7:0], b};
            pending_next = pend_eff - 2'd1;
            if (pend_eff == 2'd1)
            begin
                emit      = 1'b1;
                cmd.op    = dlsd_pkg::OP_DECODE;
                cmd.id    = rtype_eff;
                cmd.value = {asm_eff[7:0], b};
            end
            else if (item.last_byte)
            begin
                pending_next = 2'd0;
                emit         = 1'b1;
                cmd.op       = dlsd_pkg::OP_ERROR;
            end
        end
        else if (!b[7])
        begin
            emit      = 1'b1;
            cmd.op    = dlsd_pkg::OP_DECODE;
            cmd.id    = dlsd_pkg::ID_DDEPTH;
            cmd.value = {9'd0, b[6:0]};
        end
        else if ((b & dlsd_pkg::MASK_TOP3) == dlsd_pkg::PFX_DRBT)
        begin
            emit      = 1'b1;
            cmd.op    = dlsd_pkg::OP_DECODE;
            cmd.id    = dlsd_pkg::ID_DRBT;
            cmd.value = {11'd0, b[4:0]};
        end
        else if ((b & dlsd_pkg::MASK_TOP4) != dlsd_pkg::PFX_EXT)
        begin
            // A..E map to ids 2..6 through the low three bits of the high nibble
            emit      = 1'b1;
            cmd.op    = dlsd_pkg::OP_DECODE;
            cmd.id    = {2'b00, b[6:4]};
            cmd.value = {12'd0, lo};
        end
        else if (lo > dlsd_pkg::EXT_LAST)
        begin
            emit   = 1'b1;
            cmd.op = dlsd_pkg::OP_ERROR;
        end
        else
        begin
            rtype_next   = {1'b1, lo};
            asm_next     = 16'd0;
            pending_next = dlsd_pkg::ext_extra_bytes(lo);
            if (item.last_byte)
            begin
                pending_next = 2'd0;
                emit         = 1'b1;
                cmd.op       = dlsd_pkg::OP_ERROR;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_length_reg <= dlsd_pkg::HEADER_LENGTH_RESET;
            header_left_reg   <= dlsd_pkg::HEADER_LENGTH_RESET;
            pending_reg       <= 2'd0;
            rtype_reg         <= 5'd0;
            asm_reg           <= 16'd0;
        end
        else
        begin
            if (cfg_valid)
            begin
                header_length_reg <= cfg_data;
            end
            if (accept)
            begin
                header_left_reg <= header_left_next;
                pending_reg     <= pending_next;
                rtype_reg       <= rtype_next;
                asm_reg         <= asm_next;
            end
        end
    end

endmodule

### rtl/dlsd_cmd_queue.sv
module dlsd_cmd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  dlsd_pkg::cmd_t wdata,
    output logic           full,
    input  logic           pop,
    output dlsd_pkg::cmd_t rdata,
    output logic           valid
);

    localparam int PW = dlsd_pkg::CMDQ_PTR_W;

    dlsd_pkg::cmd_t  mem_reg [dlsd_pkg::CMDQ_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW:0]     count_reg;
    logic            do_push;
    logic            do_pop;

    assign full    = (count_reg == (PW+1)'(dlsd_pkg::CMDQ_DEPTH));
    assign valid   = (count_reg != '0);
    assign do_push = push && !full;
    assign do_pop  = pop && valid;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/dlsd_back.sv
module dlsd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  dlsd_pkg::cmd_t    head,
    output logic              head_pop,
    output logic              empty,
    input  logic              pop,
    output dlsd_pkg::sample_t sample
);

    localparam int PW = dlsd_pkg::RESQ_PTR_W;

    // depth is kept relative to the calibration offset, so no second adder is needed
    dlsd_pkg::total_t elapsed_reg, elapsed_next, e_elapsed;
    dlsd_pkg::total_t rel_reg, rel_next, e_rel;
    dlsd_pkg::total_t offset_reg, offset_next, e_offset;
    dlsd_pkg::total_t press_reg, press_next, e_press;
    dlsd_pkg::total_t temp_reg, temp_next, e_temp;
    dlsd_pkg::total_t rbt_reg, rbt_next, e_rbt;
    dlsd_pkg::total_t hr_reg, hr_next, e_hr;
    logic             taken_reg, taken_next, e_taken;
    logic [1:0]       tank_reg, tank_next, e_tank;
    logic             time_due_reg, time_due_next, e_time_due;
    logic             second_reg, second_next;

    dlsd_pkg::total_t  abs_v;
    logic              clr;
    logic              step;
    logic              done;
    logic              need_time;
    logic              res_valid;
    dlsd_pkg::sample_t res;

    dlsd_pkg::sample_t res_mem_reg [dlsd_pkg::RESQ_DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     rd_ptr_reg;
    logic [PW:0]       count_reg;
    logic              res_full;
    logic              res_push;
    logic              res_pop;

    assign res_full = (count_reg == (PW+1)'(dlsd_pkg::RESQ_DEPTH));
    assign empty    = (count_reg == '0);
    assign sample   = res_mem_reg[rd_ptr_reg];
    assign res_pop  = pop && !empty;
    assign step     = head_valid && !res_full;
    assign res_push = step && res_valid;
    assign head_pop = step && done;
    assign abs_v    = dlsd_pkg::total_t'(head.value);

    always_comb
    begin
        // a clear applies once, on the first cycle spent on its request
        clr        = head.clear && !second_reg;
        e_elapsed  = clr ? '0 : elapsed_reg;
        e_rel      = clr ? '0 : rel_reg;
        e_offset   = clr ? '0 : offset_reg;
        e_press    = clr ? '0 : press_reg;
        e_temp     = clr ? '0 : temp_reg;
        e_rbt      = clr ? '0 : rbt_reg;
        e_hr       = clr ? '0 : hr_reg;
        e_taken    = clr ? 1'b0 : taken_reg;
        e_tank     = clr ? 2'd0 : tank_reg;
        e_time_due = clr || time_due_reg;

        elapsed_next  = e_elapsed;
        rel_next      = e_rel;
        offset_next   = e_offset;
        press_next    = e_press;
        temp_next     = e_temp;
        rbt_next      = e_rbt;
        hr_next       = e_hr;
        taken_next    = e_taken;
        tank_next     = e_tank;
        time_due_next = e_time_due;
        second_next   = 1'b0;

        res.sample_kind  = dlsd_pkg::KIND_ERROR;
        res.sample_value = 32'sd0;
        res.tank_index   = 2'd0;
        res.last_of_run  = 1'b1;
        res_valid        = 1'b0;
        done             = 1'b1;

        need_time = (head.op == dlsd_pkg::OP_DECODE) && (head.id != dlsd_pkg::ID_TIME)
                    && e_time_due;

        if (need_time)
        begin
            // pending time result goes out first; the record itself follows once second_reg is set
            res.sample_kind  = dlsd_pkg::KIND_TIME;
            res.sample_value = dlsd_pkg::to_out(e_elapsed);
            res.last_of_run  = 1'b0;
            res_valid        = 1'b1;
            time_due_next    = 1'b0;
            second_next      = 1'b1;
            done             = 1'b0;
        end
        else
        begin
            unique case (head.op)
                dlsd_pkg::OP_CLEAR_ONLY:
                begin
                end
                dlsd_pkg::OP_ERROR:
                begin
                    res_valid = 1'b1;
                end
                dlsd_pkg::OP_DECODE:
                begin
                    res_valid = 1'b1;
                    unique case (head.id)
                        dlsd_pkg::ID_DDEPTH:
                        begin
                            rel_next         = e_rel
                                               + dlsd_pkg::total_t'($signed(head.value[6:0]));
                            res.sample_kind  = dlsd_pkg::KIND_DEPTH;
                            res.sample_value = dlsd_pkg::to_out(rel_next);
                            time_due_next    = 1'b1;
                            elapsed_next     = e_elapsed + dlsd_pkg::total_t'(3'd4);
                        end
                        dlsd_pkg::ID_DRBT:
                        begin
                            rbt_next         = e_rbt
                                               + dlsd_pkg::total_t'($signed(head.value[4:0]));
                            res.sample_kind  = dlsd_pkg::KIND_RBT;
                            res.sample_value = dlsd_pkg::to_out(rbt_next);
                        end
                        dlsd_pkg::ID_DPRESS:
                        begin
                            press_next       = e_press
                                               + dlsd_pkg::total_t'($signed(head.value[3:0]));
                            res.sample_kind  = dlsd_pkg::KIND_PRESSURE;
                            res.sample_value = dlsd_pkg::to_out(press_next);
                            res.tank_index   = e_tank;
                        end
                        dlsd_pkg::ID_DTEMP:
                        begin
                            temp_next        = e_temp
                                               + dlsd_pkg::total_t'($signed(head.value[3:0]));
                            res.sample_kind  = dlsd_pkg::KIND_TEMPERATURE;
                            res.sample_value = dlsd_pkg::to_out(temp_next);
                        end
                        dlsd_pkg::ID_TIME:
                        begin
                            res_valid     = 1'b0;
                            time_due_next = 1'b1;
                            elapsed_next  = e_elapsed
                                            + dlsd_pkg::total_t'({head.value[3:0], 2'b00});
                        end
                        dlsd_pkg::ID_DHR:
                        begin
                            hr_next          = e_hr
                                               + dlsd_pkg::total_t'($signed(head.value[3:0]));
                            res.sample_kind  = dlsd_pkg::KIND_HEARTRATE;
                            res.sample_value = dlsd_pkg::to_out(hr_next);
                        end
                        dlsd_pkg::ID_ALARM_S, dlsd_pkg::ID_ALARM_F0, dlsd_pkg::ID_ALARM_F9:
                        begin
                            res.sample_kind  = dlsd_pkg::KIND_ALARMS;
                            res.sample_value = {16'd0, head.value};
                        end
                        dlsd_pkg::ID_ADEPTH:
                        begin
                            // first absolute depth of a dive becomes the zero point
                            if (!e_taken)
                            begin
                                taken_next  = 1'b1;
                                offset_next = abs_v;
                                rel_next    = '0;
                            end
                            else
                            begin
                                rel_next = abs_v - e_offset;
                            end
                            res.sample_kind  = dlsd_pkg::KIND_DEPTH;
                            res.sample_value = dlsd_pkg::to_out(rel_next);
                            time_due_next    = 1'b1;
                            elapsed_next     = e_elapsed + dlsd_pkg::total_t'(3'd4);
                        end
                        dlsd_pkg::ID_ARBT:
                        begin
                            rbt_next         = abs_v;
                            res.sample_kind  = dlsd_pkg::KIND_RBT;
                            res.sample_value = dlsd_pkg::to_out(abs_v);
                        end
                        dlsd_pkg::ID_ATEMP:
                        begin
                            temp_next        = abs_v;
                            res.sample_kind  = dlsd_pkg::KIND_TEMPERATURE;
                            res.sample_value = dlsd_pkg::to_out(abs_v);
                        end
                        dlsd_pkg::ID_APRESS0, dlsd_pkg::ID_APRESS1, dlsd_pkg::ID_APRESS2:
                        begin
                            tank_next        = head.id[1:0];
                            press_next       = abs_v;
                            res.sample_kind  = dlsd_pkg::KIND_PRESSURE;
                            res.sample_value = dlsd_pkg::to_out(abs_v);
                            res.tank_index   = head.id[1:0];
                        end
                        dlsd_pkg::ID_AHR:
                        begin
                            hr_next          = abs_v;
                            res.sample_kind  = dlsd_pkg::KIND_HEARTRATE;
                            res.sample_value = dlsd_pkg::to_out(abs_v);
                        end
                        dlsd_pkg::ID_BEARING:
                        begin
                            res.sample_kind  = dlsd_pkg::KIND_BEARING;
                            res.sample_value = {16'd0, head.value};
                        end
                        default:
                        begin
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg  <= '0;
            rel_reg      <= '0;
            offset_reg   <= '0;
            press_reg    <= '0;
            temp_reg     <= '0;
            rbt_reg      <= '0;
            hr_reg       <= '0;
            taken_reg    <= 1'b0;
            tank_reg     <= 2'd0;
            time_due_reg <= 1'b1;
            second_reg   <= 1'b0;
        end
        else if (step)
        begin
            elapsed_reg  <= elapsed_next;
            rel_reg      <= rel_next;
            offset_reg   <= offset_next;
            press_reg    <= press_next;
            temp_reg     <= temp_next;
            rbt_reg      <= rbt_next;
            hr_reg       <= hr_next;
            taken_reg    <= taken_next;
            tank_reg     <= tank_next;
            time_due_reg <= time_due_next;
            second_reg   <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            res_mem_reg[wr_ptr_reg] <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (res_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (res_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (res_push && !res_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (res_pop && !res_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/dive_log_sample_decoder.sv
// Dive log sample decoder.
// Input queue side: drive item and push; a byte is taken on a clock edge with
// push high and full low. Results: while empty is low the oldest result sits on
// sample; pop high on an edge with empty low takes it.
// Config: cfg_data/cfg_valid write header_length; cfg_ready is always high. The
// new length is used from the next first_byte on.
// Flow: a taken byte's request goes into the request queue; the back end writes
// its result into the result queue, where it shows on sample. A time result
// comes before the record result of the same byte. Bytes are taken one per
// cycle while full is low; the back end writes one result per cycle while the
// result queue has room, and takes the next request only after both results.
// A 4-entry request queue sits between the byte parser and the back end, and
// a 4-entry result queue sits after the back end.
// Reset: header_length returns to 152, all totals clear, both queues empty.
// When pop stays low the result queue fills, the back end holds, the request
// queue fills behind it and full goes high; nothing is dropped.
module dive_log_sample_decoder (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  dlsd_pkg::item_t            item,
    output logic                       full,
    output logic                       empty,
    input  logic                       pop,
    output dlsd_pkg::sample_t          sample,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [dlsd_pkg::HDR_W-1:0] cfg_data
);

    dlsd_pkg::cmd_t front_cmd;
    dlsd_pkg::cmd_t head_cmd;
    logic           cmd_push;
    logic           cmdq_full;
    logic           head_valid;
    logic           head_pop;

    dlsd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .push      (push),
        .item      (item),
        .full      (full),
        .cmdq_full (cmdq_full),
        .cmd_push  (cmd_push),
        .cmd       (front_cmd)
    );

    dlsd_cmd_queue u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (front_cmd),
        .full  (cmdq_full),
        .pop   (head_pop),
        .rdata (head_cmd),
        .valid (head_valid)
    );

    dlsd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head_cmd),
        .head_pop   (head_pop),
        .empty      (empty),
        .pop        (pop),
        .sample     (sample)
    );

endmodule

### rtl/dlsd_checker.sv
`include "dive_log_sample_decoder_macros.svh"

module dlsd_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              empty,
    input logic              pop,
    input dlsd_pkg::sample_t sample
);

    logic is_time;
    logic is_error;
    logic is_press;

    assign is_time  = !empty && (sample.sample_kind == dlsd_pkg::KIND_TIME);
    assign is_error = !empty && (sample.sample_kind == dlsd_pkg::KIND_ERROR);
    assign is_press = sample.sample_kind == dlsd_pkg::KIND_PRESSURE;

    // a time result is never marked last of run: the record that flushed it follows
    `DLSD_ASSERT_SAME(a_time_not_last, is_time, !sample.last_of_run)
    `DLSD_ASSERT_SAME(a_error_shape, is_error, sample.last_of_run && sample.sample_value == 0)
    `DLSD_ASSERT_SAME(a_tank_only_press, !empty && !is_press, sample.tank_index == 2'd0)
    `DLSD_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(sample))

endmodule

bind dive_log_sample_decoder dlsd_checker u_checker (.*);

### tb/sv/dive_log_sample_decoder_tb.sv
`timescale 1ns / 100ps

class dive_sample_scoreboard;
    dlsd_pkg::sample_t expected_samples[$];
    dlsd_pkg::sample_t step_samples[$];
    int                mismatches;
    logic [9:0]        header_length;
    logic [9:0]        header_left;
    logic [1:0]        bytes_pending;
    logic [4:0]        record_id;
    logic [15:0]       assembled;
    logic [31:0]       elapsed_time;
    logic [31:0]       depth_total;
    logic [31:0]       depth_offset;
    logic [31:0]       pressure_total;
    logic [31:0]       temperature_total;
    logic [31:0]       rbt_total;
    logic [31:0]       heartrate_total;
    logic [1:0]        current_tank;
    bit                offset_taken;
    bit                time_due;

    function new();
        mismatches = 0;
        apply_reset();
    endfunction

    function void apply_reset();
        header_length = dlsd_pkg::HEADER_LENGTH_RESET;
        clear_dive();
    endfunction

    function void set_header_length(logic [9:0] v);
        header_length = v;
    endfunction

    function void clear_dive();
        header_left       = header_length;
        bytes_pending     = 2'd0;
        record_id         = 5'd0;
        assembled         = 16'd0;
        elapsed_time      = 32'd0;
        depth_total       = 32'd0;
        depth_offset      = 32'd0;
        offset_taken      = 1'b0;
        pressure_total    = 32'd0;
        current_tank      = 2'd0;
        temperature_total = 32'd0;
        rbt_total         = 32'd0;
        heartrate_total   = 32'd0;
        time_due          = 1'b1;
    endfunction

    function int waiting();
        return expected_samples.size();
    endfunction

    function void emit(dlsd_pkg::kind_e kind, logic [31:0] value, logic [1:0] tank);
        dlsd_pkg::sample_t s;
        s.sample_kind  = kind;
        s.sample_value = value;
        s.tank_index   = tank;
        s.last_of_run  = 1'b0;
        step_samples.push_back(s);
    endfunction

    function void decode_record(logic [4:0] id, logic [15:0] v);
        // any record but a time step flushes a pending time sample first
        if (id != dlsd_pkg::ID_TIME && time_due)
        begin
            time_due = 1'b0;
            emit(dlsd_pkg::KIND_TIME, elapsed_time, 2'd0);
        end
        case (id)
            dlsd_pkg::ID_DDEPTH:
            begin
                depth_total = depth_total + {{25{v[6]}}, v[6:0]};
                emit(dlsd_pkg::KIND_DEPTH, depth_total - depth_offset, 2'd0);
                time_due = 1'b1;
                elapsed_time = elapsed_time + 32'd4;
            end
            dlsd_pkg::ID_DRBT:
            begin
                rbt_total = rbt_total + {{27{v[4]}}, v[4:0]};
                emit(dlsd_pkg::KIND_RBT, rbt_total, 2'd0);
            end
            dlsd_pkg::ID_DPRESS:
            begin
                pressure_total = pressure_total + {{28{v[3]}}, v[3:0]};
                emit(dlsd_pkg::KIND_PRESSURE, pressure_total, current_tank);
            end
            dlsd_pkg::ID_DTEMP:
            begin
                temperature_total = temperature_total + {{28{v[3]}}, v[3:0]};
                emit(dlsd_pkg::KIND_TEMPERATURE, temperature_total, 2'd0);
            end
            dlsd_pkg::ID_TIME:
            begin
                time_due = 1'b1;
                elapsed_time = elapsed_time + {26'd0, v[3:0], 2'b00};
            end
            dlsd_pkg::ID_DHR:
            begin
                heartrate_total = heartrate_total + {{28{v[3]}}, v[3:0]};
                emit(dlsd_pkg::KIND_HEARTRATE, heartrate_total, 2'd0);
            end
            dlsd_pkg::ID_ALARM_S, dlsd_pkg::ID_ALARM_F0, dlsd_pkg::ID_ALARM_F9:
            begin
                emit(dlsd_pkg::KIND_ALARMS, {16'd0, v}, 2'd0);
            end
            dlsd_pkg::ID_ADEPTH:
            begin
                depth_total = {16'd0, v};
                if (!offset_taken)
                begin
                    offset_taken = 1'b1;
                    depth_offset = depth_total;
                end
                emit(dlsd_pkg::KIND_DEPTH, depth_total - depth_offset, 2'd0);
                time_due = 1'b1;
                elapsed_time = elapsed_time + 32'd4;
            end
            dlsd_pkg::ID_ARBT:
            begin
                rbt_total = {16'd0, v};
                emit(dlsd_pkg::KIND_RBT, rbt_total, 2'd0);
            end
            dlsd_pkg::ID_ATEMP:
            begin
                temperature_total = {16'd0, v};
                emit(dlsd_pkg::KIND_TEMPERATURE, temperature_total, 2'd0);
            end
            dlsd_pkg::ID_APRESS0, dlsd_pkg::ID_APRESS1, dlsd_pkg::ID_APRESS2:
            begin
                current_tank = 2'(id - dlsd_pkg::ID_APRESS0);
                pressure_total = {16'd0, v};
                emit(dlsd_pkg::KIND_PRESSURE, pressure_total, current_tank);
            end
            dlsd_pkg::ID_AHR:
            begin
                heartrate_total = {16'd0, v};
                emit(dlsd_pkg::KIND_HEARTRATE, heartrate_total, 2'd0);
            end
            dlsd_pkg::ID_BEARING:
            begin
                emit(dlsd_pkg::KIND_BEARING, {16'd0, v}, 2'd0);
            end
            default:
            begin
                emit(dlsd_pkg::KIND_ERROR, 32'd0, 2'd0);
            end
        endcase
    endfunction

    function void note_item(dlsd_pkg::item_t it);
        logic [7:0] b;
        b = it.data_byte;
        step_samples.delete();
        if (it.first_byte)
            clear_dive();
        if (header_left != 10'd0)
        begin
            header_left = header_left - 10'd1;
            return;
        end
        if (bytes_pending != 2'd0)
        begin
            assembled = {assembled[7:0], b};
            bytes_pending = bytes_pending - 2'd1;
            if (bytes_pending == 2'd0)
            begin
                decode_record(record_id, assembled);
            end
            else if (it.last_byte)
            begin
                // log ends in the middle of a record
                bytes_pending = 2'd0;
                emit(dlsd_pkg::KIND_ERROR, 32'd0, 2'd0);
            end
        end
        else if (!b[7])
        begin
            decode_record(dlsd_pkg::ID_DDEPTH, {9'd0, b[6:0]});
        end
        else if ((b & dlsd_pkg::MASK_TOP3) == dlsd_pkg::PFX_DRBT)
        begin
            decode_record(dlsd_pkg::ID_DRBT, {11'd0, b[4:0]});
        end
        else if ((b & dlsd_pkg::MASK_TOP4) != dlsd_pkg::PFX_EXT)
        begin
            // Ax..Ex map onto ids 2..6
            decode_record({1'b0, b[7:4]} - 5'd8, {12'd0, b[3:0]});
        end
        else if (b[3:0] > dlsd_pkg::EXT_LAST)
        begin
            emit(dlsd_pkg::KIND_ERROR, 32'd0, 2'd0);
        end
        else
        begin
            record_id = dlsd_pkg::ID_ALARM_F0 + {1'b0, b[3:0]};
            assembled = 16'd0;
            if (record_id == dlsd_pkg::ID_ALARM_F0 || record_id == dlsd_pkg::ID_ARBT ||
                record_id == dlsd_pkg::ID_AHR || record_id == dlsd_pkg::ID_ALARM_F9)
                bytes_pending = 2'd1;
            else
                bytes_pending = 2'd2;
            if (it.last_byte)
            begin
                bytes_pending = 2'd0;
                emit(dlsd_pkg::KIND_ERROR, 32'd0, 2'd0);
            end
        end
        if (step_samples.size() > 0)
        begin
            step_samples[step_samples.size() - 1].last_of_run = 1'b1;
            foreach (step_samples[i])
                expected_samples.push_back(step_samples[i]);
        end
    endfunction

    task report_mismatch(string msg);
        $display("[%0t] %s", $time, msg);
        mismatches++;
    endtask

    task check_sample(dlsd_pkg::sample_t got);
        dlsd_pkg::sample_t want;
        if (expected_samples.size() == 0)
        begin
            report_mismatch($sformatf("result with none expected: kind %0d value %0d",
                                      got.sample_kind, got.sample_value));
            return;
        end
        want = expected_samples.pop_front();
        if (got.sample_kind !== want.sample_kind)
            report_mismatch($sformatf("sample_kind got %0d want %0d",
                                      got.sample_kind, want.sample_kind));
        if (got.sample_value !== want.sample_value)
            report_mismatch($sformatf("sample_value got %0d want %0d (kind %0d)",
                                      got.sample_value, want.sample_value,
                                      want.sample_kind));
        if (got.tank_index !== want.tank_index)
            report_mismatch($sformatf("tank_index got %0d want %0d",
                                      got.tank_index, want.tank_index));
        if (got.last_of_run !== want.last_of_run)
            report_mismatch($sformatf("last_of_run got %0b want %0b (kind %0d)",
                                      got.last_of_run, want.last_of_run,
                                      want.sample_kind));
    endtask
endclass

module dive_log_sample_decoder_tb;

    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 4000;

    // record lead bytes
    localparam logic [7:0] REC_DRBT     = 8'h80;
    localparam logic [7:0] REC_DPRESS   = 8'hA0;
    localparam logic [7:0] REC_DTEMP    = 8'hB0;
    localparam logic [7:0] REC_TIME     = 8'hC0;
    localparam logic [7:0] REC_DHR      = 8'hD0;
    localparam logic [7:0] REC_ALARM    = 8'hE0;
    localparam logic [7:0] CODE_ALARM_X = 8'hF0;
    localparam logic [7:0] CODE_ADEPTH  = 8'hF1;
    localparam logic [7:0] CODE_ARBT    = 8'hF2;
    localparam logic [7:0] CODE_ATEMP   = 8'hF3;
    localparam logic [7:0] CODE_APRESS2 = 8'hF6;
    localparam logic [7:0] CODE_AHR     = 8'hF7;
    localparam logic [7:0] CODE_BEARING = 8'hF8;
    localparam logic [7:0] CODE_ALARM_Y = 8'hF9;
    localparam logic [7:0] CODE_BAD_LO  = 8'hFA;
    localparam logic [7:0] CODE_BAD_HI  = 8'hFF;

    logic                       clk;
    logic                       rst_n     = 1'b0;
    logic                       push      = 1'b0;
    dlsd_pkg::item_t            item      = '0;
    logic                       full;
    logic                       empty;
    logic                       pop       = 1'b0;
    dlsd_pkg::sample_t          sample;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [dlsd_pkg::HDR_W-1:0] cfg_data  = '0;

    dive_sample_scoreboard sb = new();

    int         send_idle = 0;
    int         recv_idle = 0;
    int         cur_hdr = 152;
    int         items_sent = 0;
    int         quiet_cycles = 0;
    logic [7:0] dive_bytes[$];

    dive_log_sample_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .empty     (empty),
        .pop       (pop),
        .sample    (sample),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
    begin
        pop <= rst_n && ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_sample(sample);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("no progress for %0d cycles, %0d results outstanding",
                         quiet_cycles, sb.waiting());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // entered and left just after a falling edge
    task automatic send_byte(input logic [7:0] b, input bit first, input bit last);
        dlsd_pkg::item_t it;
        it.data_byte  = b;
        it.first_byte = first;
        it.last_byte  = last;
        while ($urandom_range(99) < send_idle)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_item(it);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic hold_until_drained();
        push <= 1'b0;
        while (sb.waiting() != 0)
            @(negedge clk);
        // header bytes make no results but may still be in flight
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_header_length(input logic [dlsd_pkg::HDR_W-1:0] v);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_header_length(v);
        cur_hdr = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] payload_byte();
        int pick;
        pick = $urandom_range(5);
        if (pick == 0)
            return 8'h00;
        if (pick == 1)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    function automatic void add_record();
        int         pick;
        logic [7:0] code;
        pick = $urandom_range(99);
        if (pick < 30)
        begin
            dive_bytes.push_back(8'($urandom_range(127)));
        end
        else if (pick < 40)
        begin
            dive_bytes.push_back(REC_DRBT | 8'($urandom_range(31)));
        end
        else if (pick < 70)
        begin
            case ($urandom_range(4))
                0: code = REC_DPRESS;
                1: code = REC_DTEMP;
                2: code = REC_TIME;
                3: code = REC_DHR;
                default: code = REC_ALARM;
            endcase
            dive_bytes.push_back(code | 8'($urandom_range(15)));
        end
        else if (pick < 94)
        begin
            code = CODE_ALARM_X | 8'($urandom_range(9));
            dive_bytes.push_back(code);
            dive_bytes.push_back(payload_byte());
            if (!(code == CODE_ALARM_X || code == CODE_ARBT ||
                  code == CODE_AHR || code == CODE_ALARM_Y))
                dive_bytes.push_back(payload_byte());
        end
        else if (pick < 97)
        begin
            dive_bytes.push_back(8'($urandom_range(CODE_BAD_LO, CODE_BAD_HI)));
        end
        else
        begin
            dive_bytes.push_back(8'($urandom));
        end
    endfunction

    task automatic send_dive(input bit fresh, input int hdr, input int n_rec);
        int cut;
        int n_hdr;
        int rec_start;
        int n;
        cut = -1;
        dive_bytes.delete();
        if (fresh && hdr > 0 && $urandom_range(19) == 0)
            cut = $urandom_range(hdr - 1);
        n_hdr = (cut >= 0) ? cut + 1 : hdr;
        repeat (n_hdr) dive_bytes.push_back(8'($urandom));
        rec_start = n_hdr;
        if (cut < 0)
        begin
            repeat (n_rec)
            begin
                rec_start = dive_bytes.size();
                add_record();
            end
            // now and then the log stops inside the last record
            if (dive_bytes.size() - rec_start > 1 && $urandom_range(4) == 0)
                repeat ($urandom_range(1, dive_bytes.size() - rec_start - 1))
                    void'(dive_bytes.pop_back());
        end
        n = dive_bytes.size();
        for (int i = 0; i < n; i++)
            send_byte(dive_bytes[i], (i == 0 && fresh) || ($urandom_range(299) == 0),
                      i == n - 1);
    endtask

    task automatic run_random(input int target);
        bit fresh;
        while (items_sent < target)
        begin
            fresh = ($urandom_range(3) != 0);
            send_dive(fresh, fresh ? cur_hdr : 0, $urandom_range(1, 30));
        end
    endtask

    task automatic directed_records();
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'h7F, 1'b0, 1'b0);
        send_byte(8'h40, 1'b0, 1'b0);
        send_byte(REC_TIME | 8'h0F, 1'b0, 1'b0);
        send_byte(REC_DRBT | 8'h1F, 1'b0, 1'b0);
        send_byte(REC_DRBT | 8'h0F, 1'b0, 1'b0);
        send_byte(REC_DPRESS | 8'h08, 1'b0, 1'b0);
        send_byte(REC_DTEMP | 8'h07, 1'b0, 1'b0);
        send_byte(REC_DHR | 8'h0F, 1'b0, 1'b0);
        send_byte(REC_ALARM | 8'h0A, 1'b0, 1'b0);
        // first absolute depth sets the zero reference
        send_byte(CODE_ADEPTH, 1'b0, 1'b0);
        send_byte(8'h12, 1'b0, 1'b0);
        send_byte(8'h34, 1'b0, 1'b0);
        send_byte(CODE_ADEPTH, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(CODE_APRESS2, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h01, 1'b0, 1'b0);
        send_byte(CODE_BAD_HI, 1'b0, 1'b0);
        send_byte(CODE_BEARING, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        // truncated absolute temperature ends the dive
        send_byte(CODE_ATEMP, 1'b0, 1'b0);
        send_byte(8'h55, 1'b0, 1'b1);
        // decoding carries on without a new first byte
        send_byte(CODE_AHR, 1'b0, 1'b0);
        send_byte(8'h48, 1'b0, 1'b1);
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        send_idle = 26;
        recv_idle = 51;
        // first dive straight out of reset, default header length
        send_dive(1'b0, 152, 40);
        hold_until_drained();
        write_header_length(10'd0);
        directed_records();
        run_random(330);
        hold_until_drained();
        write_header_length(10'($urandom_range(1, 6)));

        send_idle = 51;
        recv_idle = 26;
        run_random(480);
        hold_until_drained();

        send_idle = 0;
        recv_idle = 0;
        write_header_length(10'd1023);
        send_dive(1'b1, 1023, 20);
        hold_until_drained();
        write_header_length(10'd2);
        run_random(1600);

        hold_until_drained();
        if (sb.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/dlsd_pkg.sv
rtl/dlsd_front.sv
rtl/dlsd_cmd_queue.sv
rtl/dlsd_back.sv
rtl/dive_log_sample_decoder.sv
rtl/dlsd_checker.sv
tb/sv/dive_log_sample_decoder_tb.sv
